[rtl/saq_pkg.sv]
// Shared constants, types and the controller/datapath command and status bundles.
`default_nettype none

package saq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int OP_W     = 2;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int KEY_W    = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } t_time;

    typedef enum logic [OP_W-1:0] {
        OP_ADD       = 2'd0,
        OP_DEL       = 2'd1,
        OP_DEL_FIRST = 2'd2,
        OP_QUERY     = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DONE      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        RD_PTR  = 2'd0,
        RD_PREV = 2'd1,
        RD_NEXT = 2'd2
    } t_rd_sel;

    typedef enum logic {
        WR_SHIFT = 1'b0,
        WR_KEY   = 1'b1
    } t_wr_sel;

    typedef enum logic [1:0] {
        PTR_HOLD  = 2'd0,
        PTR_INC   = 2'd1,
        PTR_DEC   = 2'd2,
        PTR_COUNT = 2'd3
    } t_ptr_op;

    typedef enum logic [1:0] {
        POS_HOLD  = 2'd0,
        POS_PTR   = 2'd1,
        POS_COUNT = 2'd2
    } t_pos_op;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        t_ptr_op ptr_op;
        t_pos_op pos_op;
        logic    count_inc;
        logic    count_dec;
        logic    st_en;
        t_status st;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic empty;
        logic key_eq;
        logic key_le;
        logic scan_last;
        logic at_pos;
        logic shift_end;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/sorted_alarm_queue.sv]
// Top level: sorted alarm time table with add, delete, delete-earliest and query.
// Each input word is one operation and yields one result word with the status, the slot
// touched, the entry count and the earliest stored time after the operation. Operations
// run one at a time. A query, a refused add or a delete on an empty table goes from the
// decode step straight to the result step. Otherwise an add compares its time against the
// stored entries in order, stops on an equal time, moves later entries up one slot and
// writes its time, or appends it; a delete searches the same way, or takes slot zero, and
// moves later entries down. Every compare or move reads one entry through the single
// table read port and waits for the registered read data. A new word is taken once the
// previous result sits in the output register, and the result register holds until taken.
`default_nettype none

module sorted_alarm_queue import saq_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [OP_W-1:0]     i_op,
    input  wire logic [YEAR_W-1:0]   i_year,
    input  wire logic [MONTH_W-1:0]  i_month,
    input  wire logic [DAY_W-1:0]    i_day,
    input  wire logic [HOUR_W-1:0]   i_hour,
    input  wire logic [MINUTE_W-1:0] i_minute,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic [POS_W-1:0]         o_position,
    output logic [COUNT_W-1:0]       o_entry_count,
    output logic                     o_first_valid,
    output logic [YEAR_W-1:0]        o_first_year,
    output logic [MONTH_W-1:0]       o_first_month,
    output logic [DAY_W-1:0]         o_first_day,
    output logic [HOUR_W-1:0]        o_first_hour,
    output logic [MINUTE_W-1:0]      o_first_minute
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    saq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    saq_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_op           (i_op),
        .i_year         (i_year),
        .i_month        (i_month),
        .i_day          (i_day),
        .i_hour         (i_hour),
        .i_minute       (i_minute),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_position     (o_position),
        .o_entry_count  (o_entry_count),
        .o_first_valid  (o_first_valid),
        .o_first_year   (o_first_year),
        .o_first_month  (o_first_month),
        .o_first_day    (o_first_day),
        .o_first_hour   (o_first_hour),
        .o_first_minute (o_first_minute)
    );

endmodule

`default_nettype wire

[rtl/saq_datapath.sv]
// Datapath: sorted time table, walk pointer, target slot, count and result register.
`default_nettype none

module saq_datapath import saq_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_stat                 o_stat,
    input  wire logic [OP_W-1:0]     i_op,
    input  wire logic [YEAR_W-1:0]   i_year,
    input  wire logic [MONTH_W-1:0]  i_month,
    input  wire logic [DAY_W-1:0]    i_day,
    input  wire logic [HOUR_W-1:0]   i_hour,
    input  wire logic [MINUTE_W-1:0] i_minute,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic [POS_W-1:0]         o_position,
    output logic [COUNT_W-1:0]       o_entry_count,
    output logic                     o_first_valid,
    output logic [YEAR_W-1:0]        o_first_year,
    output logic [MONTH_W-1:0]       o_first_month,
    output logic [DAY_W-1:0]         o_first_day,
    output logic [HOUR_W-1:0]        o_first_hour,
    output logic [MINUTE_W-1:0]      o_first_minute
);

    logic [KEY_W-1:0] r_mem [QUEUE_DEPTH];
    logic [KEY_W-1:0] r_rdata;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_first;
    t_op              r_op;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_ptr;
    logic [IDX_W-1:0] r_pos;
    t_status          r_st;

    logic             r_out_valid;
    t_status          r_out_status;
    logic [IDX_W-1:0] r_out_pos;
    logic [CNT_W-1:0] r_out_count;
    logic             r_out_first_valid;
    t_time            r_out_first;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_data;
    logic [CNT_W-1:0] ptr_plus;

    assign ptr_plus = r_ptr + CNT_W'(1);

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_PTR:  rd_addr = r_ptr[IDX_W-1:0];
            RD_PREV: rd_addr = IDX_W'(r_ptr - CNT_W'(1));
            RD_NEXT: rd_addr = ptr_plus[IDX_W-1:0];
            default: rd_addr = r_ptr[IDX_W-1:0];
        endcase
    end

    always_comb begin
        unique case (i_cmd.wr_sel)
            WR_SHIFT: begin
                wr_addr = r_ptr[IDX_W-1:0];
                wr_data = r_rdata;
            end
            WR_KEY: begin
                wr_addr = r_pos;
                wr_data = r_key;
            end
            default: begin
                wr_addr = r_ptr[IDX_W-1:0];
                wr_data = r_rdata;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // mirror slot zero so the earliest entry needs no read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && (wr_addr == '0)) begin
            r_first <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= {i_year, i_month, i_day, i_hour, i_minute};
            r_op  <= t_op'(i_op);
        end
        if (i_cmd.st_en) begin
            r_st <= i_cmd.st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ptr <= '0;
        end else begin
            case (i_cmd.ptr_op)
                PTR_INC:   r_ptr <= ptr_plus;
                PTR_DEC:   r_ptr <= r_ptr - CNT_W'(1);
                PTR_COUNT: r_ptr <= r_count;
                default:   r_ptr <= r_ptr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos <= '0;
        end else begin
            case (i_cmd.pos_op)
                POS_PTR:   r_pos <= r_ptr[IDX_W-1:0];
                POS_COUNT: r_pos <= r_count[IDX_W-1:0];
                default:   r_pos <= r_pos;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.count_inc) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.count_dec) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status      <= r_st;
            r_out_pos         <= r_pos;
            r_out_count       <= r_count;
            r_out_first_valid <= (r_count != '0);
            r_out_first       <= (r_count != '0) ? t_time'(r_first) : t_time'('0);
        end
    end

    always_comb begin
        o_stat.op        = r_op;
        o_stat.full      = (r_count == CNT_W'(QUEUE_DEPTH));
        o_stat.empty     = (r_count == '0);
        o_stat.key_eq    = (r_key == r_rdata);
        o_stat.key_le    = (r_key <= r_rdata);
        o_stat.scan_last = (ptr_plus == r_count);
        o_stat.at_pos    = (r_ptr == CNT_W'(r_pos));
        o_stat.shift_end = (ptr_plus >= r_count);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_position     = POS_W'(r_out_pos);
    assign o_entry_count  = COUNT_W'(r_out_count);
    assign o_first_valid  = r_out_first_valid;
    assign o_first_year   = r_out_first.year;
    assign o_first_month  = r_out_first.month;
    assign o_first_day    = r_out_first.day;
    assign o_first_hour   = r_out_first.hour;
    assign o_first_minute = r_out_first.minute;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds table depth");

    a_no_inc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.count_inc |-> (r_count < CNT_W'(QUEUE_DEPTH)))
        else $error("insert into full table");

    a_no_dec_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.count_dec |-> (r_count != '0))
        else $error("remove from empty table");

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> (CNT_W'(wr_addr) <= r_count))
        else $error("table write beyond stored entries");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result word overwritten before taken");
`endif

endmodule

`default_nettype wire

[rtl/saq_ctrl.sv]
// Controller: sequences search, shift, insert and result steps for one word.
`default_nettype none

module saq_ctrl import saq_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_DECODE = 10'b00_0000_0010,
        S_SRD    = 10'b00_0000_0100,
        S_SCMP   = 10'b00_0000_1000,
        S_SUR    = 10'b00_0001_0000,
        S_SUW    = 10'b00_0010_0000,
        S_INS    = 10'b00_0100_0000,
        S_SDR    = 10'b00_1000_0000,
        S_SDW    = 10'b01_0000_0000,
        S_FIN    = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.op) inside
                    OP_ADD: begin
                        if (i_stat.full) begin
                            o_cmd.st_en = 1'b1;
                            o_cmd.st    = ST_FULL;
                            n_state     = S_FIN;
                        end else if (i_stat.empty) begin
                            n_state = S_INS;
                        end else begin
                            n_state = S_SRD;
                        end
                    end
                    OP_DEL, OP_DEL_FIRST: begin
                        if (i_stat.empty) begin
                            o_cmd.st_en = 1'b1;
                            o_cmd.st    = ST_NOT_FOUND;
                            n_state     = S_FIN;
                        end else if (i_stat.op == OP_DEL) begin
                            n_state = S_SRD;
                        end else begin
                            n_state = S_SDR;
                        end
                    end
                    OP_QUERY: begin
                        o_cmd.st_en = 1'b1;
                        o_cmd.st    = ST_DONE;
                        n_state     = S_FIN;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_SRD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_PTR;
                n_state      = S_SCMP;
            end
            S_SCMP: begin
                if (i_stat.op == OP_ADD) begin
                    if (i_stat.key_le && i_stat.key_eq) begin
                        o_cmd.pos_op = POS_PTR;
                        o_cmd.st_en  = 1'b1;
                        o_cmd.st     = ST_PRESENT;
                        n_state      = S_FIN;
                    end else if (i_stat.key_le) begin
                        o_cmd.pos_op = POS_PTR;
                        o_cmd.ptr_op = PTR_COUNT;
                        n_state      = S_SUR;
                    end else if (i_stat.scan_last) begin
                        o_cmd.pos_op = POS_COUNT;
                        n_state      = S_INS;
                    end else begin
                        o_cmd.ptr_op = PTR_INC;
                        n_state      = S_SRD;
                    end
                end else begin
                    if (i_stat.key_eq) begin
                        o_cmd.pos_op = POS_PTR;
                        n_state      = S_SDR;
                    end else if (i_stat.scan_last) begin
                        o_cmd.st_en = 1'b1;
                        o_cmd.st    = ST_NOT_FOUND;
                        n_state     = S_FIN;
                    end else begin
                        o_cmd.ptr_op = PTR_INC;
                        n_state      = S_SRD;
                    end
                end
            end
            S_SUR: begin
                if (i_stat.at_pos) begin
                    n_state = S_INS;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_PREV;
                    n_state      = S_SUW;
                end
            end
            S_SUW: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_SHIFT;
                o_cmd.ptr_op = PTR_DEC;
                n_state      = S_SUR;
            end
            S_INS: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.wr_sel    = WR_KEY;
                o_cmd.count_inc = 1'b1;
                o_cmd.st_en     = 1'b1;
                o_cmd.st        = ST_INSERTED;
                n_state         = S_FIN;
            end
            S_SDR: begin
                if (i_stat.shift_end) begin
                    o_cmd.count_dec = 1'b1;
                    o_cmd.st_en     = 1'b1;
                    o_cmd.st        = ST_DONE;
                    n_state         = S_FIN;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                    n_state      = S_SDW;
                end
            end
            S_SDW: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_SHIFT;
                o_cmd.ptr_op = PTR_INC;
                n_state      = S_SDR;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[verif/sorted_alarm_queue_test.sv]
// Self-checking testbench for the sorted alarm queue against a table predictor.
module sorted_alarm_queue_test import saq_pkg::*; ();

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        t_status             status;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  count;
        logic                first_valid;
        t_time               first;
    } t_alarm_result;

    class alarm_table_scoreboard;
        logic [KEY_W-1:0] slots[QUEUE_DEPTH];
        int unsigned      filled;
        t_alarm_result    pending_q[$];
        int unsigned      errors;

        function new();
            filled = 0;
            errors = 0;
        endfunction

        function int unsigned pending();
            return pending_q.size();
        endfunction

        function t_time stored_time(int unsigned idx);
            return t_time'(slots[idx]);
        endfunction

        function void remove_at(int unsigned pos);
            for (int unsigned k = pos; k + 1 < filled; k++) begin
                slots[k] = slots[k + 1];
            end
            filled--;
        endfunction

        function void note_input(t_op op, t_time tm);
            t_alarm_result    r;
            logic [KEY_W-1:0] key;
            int unsigned      i;
            logic             found;
            key        = tm;
            r.status   = ST_DONE;
            r.position = '0;
            case (op)
                OP_ADD: begin
                    if (filled >= QUEUE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        i = 0;
                        while (i < filled && key > slots[i]) i++;
                        if (i < filled && slots[i] == key) begin
                            r.status = ST_PRESENT;
                        end else begin
                            for (int unsigned k = filled; k > i; k--) begin
                                slots[k] = slots[k - 1];
                            end
                            slots[i] = key;
                            filled++;
                            r.status = ST_INSERTED;
                        end
                        r.position = POS_W'(i);
                    end
                end
                OP_DEL: begin
                    r.status = ST_NOT_FOUND;
                    found    = 1'b0;
                    for (int unsigned k = 0; k < filled && !found; k++) begin
                        if (slots[k] == key) begin
                            found      = 1'b1;
                            r.status   = ST_DONE;
                            r.position = POS_W'(k);
                            remove_at(k);
                        end
                    end
                end
                OP_DEL_FIRST: begin
                    if (filled == 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        remove_at(0);
                    end
                end
                default: ;
            endcase
            r.count       = COUNT_W'(filled);
            r.first_valid = (filled > 0);
            r.first       = (filled > 0) ? t_time'(slots[0]) : '0;
            pending_q.push_back(r);
        endfunction

        function void field_check(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_alarm_result act);
            t_alarm_result e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result word: expected none actual status %0d",
                         $time, act.status);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            field_check("status", e.status, act.status);
            field_check("position", e.position, act.position);
            field_check("entry_count", e.count, act.count);
            field_check("first_valid", e.first_valid, act.first_valid);
            field_check("first_year", e.first.year, act.first.year);
            field_check("first_month", e.first.month, act.first.month);
            field_check("first_day", e.first.day, act.first.day);
            field_check("first_hour", e.first.hour, act.first.hour);
            field_check("first_minute", e.first.minute, act.first.minute);
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [OP_W-1:0]     i_op;
    logic [YEAR_W-1:0]   i_year;
    logic [MONTH_W-1:0]  i_month;
    logic [DAY_W-1:0]    i_day;
    logic [HOUR_W-1:0]   i_hour;
    logic [MINUTE_W-1:0] i_minute;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [STATUS_W-1:0] o_status;
    logic [POS_W-1:0]    o_position;
    logic [COUNT_W-1:0]  o_entry_count;
    logic                o_first_valid;
    logic [YEAR_W-1:0]   o_first_year;
    logic [MONTH_W-1:0]  o_first_month;
    logic [DAY_W-1:0]    o_first_day;
    logic [HOUR_W-1:0]   o_first_hour;
    logic [MINUTE_W-1:0] o_first_minute;

    alarm_table_scoreboard sb;
    int unsigned           cycle_count = 0;
    int                    hold_cycles;
    bit                    steady;

    sorted_alarm_queue i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_year         (i_year),
        .i_month        (i_month),
        .i_day          (i_day),
        .i_hour         (i_hour),
        .i_minute       (i_minute),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_position     (o_position),
        .o_entry_count  (o_entry_count),
        .o_first_valid  (o_first_valid),
        .o_first_year   (o_first_year),
        .o_first_month  (o_first_month),
        .o_first_day    (o_first_day),
        .o_first_hour   (o_first_hour),
        .o_first_minute (o_first_minute)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic t_time mk_time(int y, int m, int d, int h, int mi);
        t_time tm;
        tm.year   = YEAR_W'(y);
        tm.month  = MONTH_W'(m);
        tm.day    = DAY_W'(d);
        tm.hour   = HOUR_W'(h);
        tm.minute = MINUTE_W'(mi);
        return tm;
    endfunction

    function automatic t_time rand_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return t_time'($urandom);
        if (r < 30) begin
            return mk_time($urandom_range(0, 4095), $urandom_range(1, 12),
                           $urandom_range(1, 31), $urandom_range(0, 23), $urandom_range(0, 59));
        end
        return mk_time(2020 + $urandom_range(0, 2), $urandom_range(1, 3),
                       $urandom_range(1, 3), $urandom_range(0, 2), $urandom_range(0, 3));
    endfunction

    function automatic t_time stored_or_random(int pct);
        if (sb.filled > 0 && $urandom_range(0, 99) < pct) begin
            return sb.stored_time($urandom_range(0, sb.filled - 1));
        end
        return rand_time();
    endfunction

    task automatic send_word(input t_op op, input t_time tm);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_year     <= tm.year;
        i_month    <= tm.month;
        i_day      <= tm.day;
        i_hour     <= tm.hour;
        i_minute   <= tm.minute;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_input(op, tm);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_alarm_result act;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            act.status       = t_status'(o_status);
            act.position     = o_position;
            act.count        = o_entry_count;
            act.first_valid  = o_first_valid;
            act.first.year   = o_first_year;
            act.first.month  = o_first_month;
            act.first.day    = o_first_day;
            act.first.hour   = o_first_hour;
            act.first.minute = o_first_minute;
            sb.check_result(act);
        end
    end

    initial begin
        int len;
        int hold;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (hold_cycles > 0) begin
                hold        = hold_cycles;
                hold_cycles = 0;
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end else begin
                len = idle_len();
                i_out_ready <= (len == 0);
                repeat ((len == 0) ? $urandom_range(1, 4) : len) @(posedge i_clk);
            end
        end
    end

    initial begin
        int    done_items;
        int    seg_len;
        int    add_pct;
        int    r;
        t_time top;
        sb          = new();
        hold_cycles = 0;
        steady      = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_op       <= OP_QUERY;
        i_year     <= '0;
        i_month    <= '0;
        i_day      <= '0;
        i_hour     <= '0;
        i_minute   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        top = mk_time(4095, 15, 31, 31, 63);
        send_word(OP_QUERY, mk_time(0, 0, 0, 0, 0));
        send_word(OP_DEL_FIRST, mk_time(0, 0, 0, 0, 0));
        send_word(OP_DEL, mk_time(2024, 6, 15, 12, 30));
        send_word(OP_ADD, top);
        send_word(OP_ADD, mk_time(0, 0, 0, 0, 0));
        send_word(OP_ADD, top);
        send_word(OP_DEL, mk_time(2024, 6, 15, 12, 30));
        for (int k = 0; k < 14; k++) begin
            send_word(OP_ADD, mk_time(2024 + k % 2, 1 + (k * 5) % 12, 1 + (k * 11) % 31,
                                      (k * 7) % 24, (k * 13) % 60));
        end
        send_word(OP_ADD, top);
        send_word(OP_ADD, mk_time(1, 1, 1, 1, 1));
        send_word(OP_DEL, top);
        send_word(OP_DEL_FIRST, rand_time());
        send_word(OP_QUERY, rand_time());

        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            seg_len = $urandom_range(20, 80);
            case ($urandom_range(0, 3))
                0:       add_pct = 25;
                1:       add_pct = 50;
                2:       add_pct = 70;
                default: add_pct = 90;
            endcase
            steady = ($urandom_range(0, 4) == 0);
            for (int j = 0; j < seg_len && done_items < RANDOM_ITEMS; j++) begin
                if (done_items == 300 || done_items == 1000) hold_cycles = HOLD_CYCLES;
                r = $urandom_range(0, 99);
                if (r < add_pct) begin
                    send_word(OP_ADD, stored_or_random(25));
                end else begin
                    r = $urandom_range(0, 9);
                    if (r < 5) send_word(OP_DEL, stored_or_random(75));
                    else if (r < 8) send_word(OP_DEL_FIRST, rand_time());
                    else send_word(OP_QUERY, rand_time());
                end
                done_items++;
            end
        end
        steady = 1'b0;
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
